// ===== src/cht_pkg.sv =====
package cht_pkg;

  // Table geometry
  localparam int NUM_BUCKETS = 1024;
  localparam int POOL_DEPTH  = 1024;

  localparam int BKT_W   = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int NODE_AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  // Node pointers are index plus one, zero marks the end of a chain
  localparam int PTR_W   = $clog2(POOL_DEPTH + 1);

  // Field widths
  localparam int KEY_W    = 31;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;

  // Shared multiplier operand width
  localparam int MUL_W = 32;

  // Golden ratio fraction as unsigned 0.64 fixed point
  localparam logic [2*MUL_W-1:0] PHI_FRAC = 64'h9E3779B97F4A7C15;
  localparam logic [MUL_W-1:0]   PHI_LO   = PHI_FRAC[MUL_W-1:0];
  localparam logic [MUL_W-1:0]   PHI_HI   = PHI_FRAC[2*MUL_W-1:MUL_W];

  // Operation codes
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UPDATED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  // One pool node as stored in memory
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic [PTR_W-1:0] link;
  } node_t;

  // Hash unit control and status
  typedef struct packed {
    logic             start;
    logic [KEY_W-1:0] key;
  } hash_req_t;

  typedef struct packed {
    logic             done;
    logic [BKT_W-1:0] bucket;
  } hash_rsp_t;

endpackage

// ===== src/cht_req_if.sv =====
interface cht_req_if import cht_pkg::*; ();

  logic             valid;
  logic             ready;
  logic             func;
  logic [KEY_W-1:0] key;
  logic [VAL_W-1:0] value;

  modport source (output valid, output func, output key, output value, input ready);
  modport sink   (input valid, input func, input key, input value, output ready);

endinterface

// ===== src/cht_rsp_if.sv =====
interface cht_rsp_if import cht_pkg::*; ();

  logic                valid;
  logic                ready;
  logic                found;
  logic [VAL_W-1:0]    value_out;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output found, output value_out, output status, input ready);
  modport sink   (input valid, input found, input value_out, input status, output ready);

endinterface

// ===== src/cht_ram.sv =====
module cht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write one entry, read one entry into the output register
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/cht_hash.sv =====
module cht_hash import cht_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  hash_req_t req,
  output hash_rsp_t rsp
);

  localparam logic [2:0] HS_IDLE = 3'd0;
  localparam logic [2:0] HS_M0   = 3'd1;
  localparam logic [2:0] HS_M1   = 3'd2;
  localparam logic [2:0] HS_M2   = 3'd3;
  localparam logic [2:0] HS_M3   = 3'd4;
  localparam logic [2:0] HS_SUM  = 3'd5;

  localparam logic [MUL_W-1:0] BUCKETS_M = MUL_W'(NUM_BUCKETS);

  logic [2:0]         state_r, state_nxt;
  logic               done_r;
  logic [KEY_W-1:0]   key_r;
  logic [2*MUL_W-1:0] prod_r;
  logic [MUL_W-1:0]   lo_r;
  logic [MUL_W-1:0]   hpart_r;
  logic [MUL_W-1:0]   hi_r;
  logic [MUL_W-1:0]   t_r;
  logic [BKT_W-1:0]   bucket_r;

  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [2*MUL_W-1:0] mul_p;
  logic [2*MUL_W-1:0] sum;

  // Select operands of the shared multiplier per step
  always_comb begin
    mul_a = {{(MUL_W-KEY_W){1'b0}}, key_r};
    mul_b = PHI_LO;
    case (state_r)
      HS_M0: begin
        mul_a = {{(MUL_W-KEY_W){1'b0}}, key_r};
        mul_b = PHI_LO;
      end
      HS_M1: begin
        mul_a = {{(MUL_W-KEY_W){1'b0}}, key_r};
        mul_b = PHI_HI;
      end
      HS_M2: begin
        mul_a = lo_r;
        mul_b = BUCKETS_M;
      end
      HS_M3: begin
        mul_a = hi_r;
        mul_b = BUCKETS_M;
      end
      default: begin
        mul_a = {{(MUL_W-KEY_W){1'b0}}, key_r};
        mul_b = PHI_LO;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;
  assign sum   = prod_r + {{MUL_W{1'b0}}, t_r};

  // Step sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      HS_IDLE: if (req.start) state_nxt = HS_M0;
      HS_M0:   state_nxt = HS_M1;
      HS_M1:   state_nxt = HS_M2;
      HS_M2:   state_nxt = HS_M3;
      HS_M3:   state_nxt = HS_SUM;
      HS_SUM:  state_nxt = HS_IDLE;
      default: state_nxt = HS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= HS_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == HS_SUM);
    end
  end

  // Datapath: register every product before it is used
  always_ff @(posedge clk) begin
    if (state_r == HS_IDLE && req.start) begin
      key_r <= req.key;
    end
    prod_r <= mul_p;
    if (state_r == HS_M1) begin
      lo_r    <= prod_r[MUL_W-1:0];
      hpart_r <= prod_r[2*MUL_W-1:MUL_W];
    end
    if (state_r == HS_M2) begin
      // High word of the fraction, kept modulo 2^32
      hi_r <= hpart_r + prod_r[MUL_W-1:0];
    end
    if (state_r == HS_M3) begin
      t_r <= prod_r[2*MUL_W-1:MUL_W];
    end
    if (state_r == HS_SUM) begin
      // Integer part stays below the bucket count
      bucket_r <= sum[MUL_W+BKT_W-1:MUL_W];
    end
  end

  assign rsp.done   = done_r;
  assign rsp.bucket = bucket_r;

endmodule

// ===== src/chained_hash_table_engine_unit.sv =====
// Flow: an input transfer starts the hash on the one shared multiplier, then the bucket
//   head is read, then one node read per chain node visited, one more step if not found.
// Items are handled one at a time by the chain walk, one node memory read per cycle;
//   a new input is taken only after the last result is loaded into the output register.
// Reset: synchronous, active low; all NUM_BUCKETS (1024) bucket heads are then cleared
//   in turn, during which no input is taken.
module chained_hash_table_engine_unit import cht_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  cht_req_if.sink    in_req,
  cht_rsp_if.source  out_rsp
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_HEAD  = 3'd3;
  localparam logic [2:0] S_NODE  = 3'd4;
  localparam logic [2:0] S_MISS  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  localparam int NODE_W = $bits(node_t);

  logic [2:0]          state_r, state_nxt;
  logic [BKT_W-1:0]    clr_cnt_r;
  logic [PTR_W-1:0]    nodes_used_r;
  logic                out_valid_r;

  logic                func_r;
  logic [KEY_W-1:0]    key_r;
  logic [VAL_W-1:0]    val_r;
  logic [PTR_W-1:0]    head_r;
  logic [PTR_W-1:0]    cur_r;
  logic                res_found_r;
  logic [VAL_W-1:0]    res_val_r;
  logic [STATUS_W-1:0] res_status_r;
  logic                out_found_r;
  logic [VAL_W-1:0]    out_val_r;
  logic [STATUS_W-1:0] out_status_r;

  hash_req_t hreq;
  hash_rsp_t hrsp;

  logic               bkt_we;
  logic [BKT_W-1:0]   bkt_waddr;
  logic [PTR_W-1:0]   bkt_wdata;
  logic [PTR_W-1:0]   bkt_rdata;

  logic               node_we;
  logic [NODE_AW-1:0] node_waddr;
  node_t              node_wdata;
  logic [NODE_AW-1:0] node_raddr;
  logic [NODE_W-1:0]  node_rword;
  node_t              node_rd;

  logic in_xfer, out_load, key_hit, pool_full;

  cht_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (hreq),
    .rsp   (hrsp)
  );

  cht_ram #(.WIDTH(PTR_W), .DEPTH(NUM_BUCKETS)) u_bkt_ram (
    .clk   (clk),
    .we    (bkt_we),
    .waddr (bkt_waddr),
    .wdata (bkt_wdata),
    .raddr (hrsp.bucket),
    .rdata (bkt_rdata)
  );

  cht_ram #(.WIDTH(NODE_W), .DEPTH(POOL_DEPTH)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .raddr (node_raddr),
    .rdata (node_rword)
  );

  assign node_rd   = node_t'(node_rword);
  assign in_xfer   = in_req.valid && in_req.ready;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_rsp.ready);
  assign key_hit   = (node_rd.key == key_r);
  assign pool_full = (nodes_used_r >= PTR_W'(POOL_DEPTH));

  assign in_req.ready = (state_r == S_IDLE);
  assign hreq.start   = in_xfer;
  assign hreq.key     = in_req.key;

  // Walk sequencer and memory port control
  always_comb begin
    state_nxt  = state_r;
    bkt_we     = 1'b0;
    bkt_waddr  = hrsp.bucket;
    bkt_wdata  = nodes_used_r + 1'b1;
    node_we    = 1'b0;
    node_waddr = NODE_AW'(nodes_used_r);
    node_wdata = '{key: key_r, value: val_r, link: head_r};
    node_raddr = NODE_AW'(cur_r - 1'b1);
    case (state_r)
      S_CLEAR: begin
        bkt_we    = 1'b1;
        bkt_waddr = clr_cnt_r;
        bkt_wdata = '0;
        if (clr_cnt_r == BKT_W'(NUM_BUCKETS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_xfer) state_nxt = S_HASH;
      end
      S_HASH: begin
        if (hrsp.done) state_nxt = S_HEAD;
      end
      S_HEAD: begin
        node_raddr = NODE_AW'(bkt_rdata - 1'b1);
        if (bkt_rdata == '0) state_nxt = S_MISS;
        else state_nxt = S_NODE;
      end
      S_NODE: begin
        node_raddr = NODE_AW'(node_rd.link - 1'b1);
        if (key_hit) begin
          // Update in place on an insert of a present key
          node_we    = (func_r == FUNC_INSERT);
          node_waddr = NODE_AW'(cur_r - 1'b1);
          node_wdata = '{key: key_r, value: val_r, link: node_rd.link};
          state_nxt  = S_DONE;
        end else if (node_rd.link == '0) begin
          state_nxt = S_MISS;
        end
      end
      S_MISS: begin
        // On an insert with room in the pool, allocate the next pool node and link it at the chain head
        if (func_r == FUNC_INSERT && !pool_full) begin
          node_we = 1'b1;
          bkt_we  = 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      nodes_used_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (state_r == S_MISS && func_r == FUNC_INSERT && !pool_full) begin
        nodes_used_r <= nodes_used_r + 1'b1;
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_rsp.ready) out_valid_r <= 1'b0;
    end
  end

  // Item, walk and result registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      func_r <= in_req.func;
      key_r  <= in_req.key;
      val_r  <= in_req.value;
    end
    if (state_r == S_HEAD) begin
      head_r <= bkt_rdata;
      cur_r  <= bkt_rdata;
    end
    if (state_r == S_NODE && !key_hit) begin
      cur_r <= node_rd.link;
    end
    if (state_r == S_NODE && key_hit) begin
      res_found_r <= 1'b1;
      if (func_r == FUNC_LOOKUP) begin
        res_val_r    <= node_rd.value;
        res_status_r <= ST_DONE;
      end else begin
        res_val_r    <= '0;
        res_status_r <= ST_UPDATED;
      end
    end
    if (state_r == S_MISS) begin
      res_found_r  <= 1'b0;
      res_val_r    <= '0;
      res_status_r <= (func_r == FUNC_INSERT && pool_full) ? ST_FULL : ST_DONE;
    end
    // Hold the result in the output register until its transfer
    if (out_load) begin
      out_found_r  <= res_found_r;
      out_val_r    <= res_val_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_rsp.valid     = out_valid_r;
  assign out_rsp.found     = out_found_r;
  assign out_rsp.value_out = out_val_r;
  assign out_rsp.status    = out_status_r;

endmodule
